// ----- sv/sdrf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record framer package
// Shared constants, types and helper functions for the sample digitizer
// record framer.
// ----------------------------------------------------------------------------
package sdrf_pkg;

    localparam int VOLT_W   = 24;
    localparam int DIFF_W   = VOLT_W + 1;
    localparam int GAIN_W   = 32;
    localparam int BITS_W   = 5;
    localparam int RLEN_W   = 23;
    localparam int POS_W    = 22;
    localparam int TIME_W   = 48;
    localparam int CODE_W   = 16;
    localparam int RNUM_W   = 32;
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    localparam int PROD_FRAC = 28;
    localparam int CFG_W    = 32;

    // Longest record, also used when the length register holds zero.
    localparam logic [RLEN_W-1:0] POS_LIMIT = RLEN_W'(4194304);

    // Reset values of the configuration registers.
    localparam logic [VOLT_W-1:0] VOLT_MIN_RST    = VOLT_W'(-262144);
    localparam logic [GAIN_W-1:0] CODE_GAIN_RST   = GAIN_W'(131072);
    localparam logic [BITS_W-1:0] SAMPLE_BITS_RST = BITS_W'(8);
    localparam logic [RLEN_W-1:0] REC_LEN_RST     = POS_LIMIT;

    typedef enum logic [1:0] {
        CFG_VOLT_MIN    = 2'd0,
        CFG_CODE_GAIN   = 2'd1,
        CFG_SAMPLE_BITS = 2'd2,
        CFG_REC_LENGTH  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_START  = 1'b0,
        MODE_SAMPLE = 1'b1
    } item_mode_t;

    // Record tag that travels with a kept sample through the quantizer.
    typedef struct packed {
        logic [RNUM_W-1:0] record_number;
        logic              record_last;
    } frame_tag_t;

    // Largest code for a given bit depth; depths above 16 act as 16.
    function automatic logic [CODE_W-1:0] code_ceiling(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] eff;
        logic [CODE_W:0]   full;
        eff  = (bits > BITS_W'(CODE_W)) ? BITS_W'(CODE_W) : bits;
        full = (17'd1 << eff) - 17'd1;
        return full[CODE_W-1:0];
    endfunction

    // Record length with out-of-range settings mapped to the longest record.
    function automatic logic [RLEN_W-1:0] eff_length(input logic [RLEN_W-1:0] len);
        return (len == '0 || len > POS_LIMIT) ? POS_LIMIT : len;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sdrf_frame_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record framer control
// Holds the skip threshold and record counters, decides which samples are
// kept and tags each kept sample with its record number and last flag.
// ----------------------------------------------------------------------------
module sdrf_frame_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       mode,
    input  wire logic [47:0]                time_index,
    input  wire logic                       block_end,
    input  wire logic [22:0]                record_length,
    output logic                            keep,
    output sdrf_pkg::frame_tag_t            tag
);
    import sdrf_pkg::*;

    logic [TIME_W-1:0] skip_threshold_reg;
    logic [TIME_W-1:0] skip_threshold_next;
    logic [TIME_W-1:0] threshold_in_block_reg;
    logic [TIME_W-1:0] threshold_in_block_next;
    logic              in_block_reg;
    logic              in_block_next;
    logic [POS_W-1:0]  record_position_reg;
    logic [POS_W-1:0]  record_position_next;
    logic [RNUM_W-1:0] record_count_reg;
    logic [RNUM_W-1:0] record_count_next;

    logic [TIME_W-1:0] threshold;
    logic [RLEN_W-1:0] pos_inc;
    logic              fills;

    // The drop test uses the threshold latched at block start.
    assign threshold = in_block_reg ? threshold_in_block_reg : skip_threshold_reg;
    assign keep      = (mode == MODE_SAMPLE) && (time_index >= threshold);
    assign pos_inc   = {1'b0, record_position_reg} + RLEN_W'(1);
    assign fills     = (pos_inc == eff_length(record_length));

    assign tag = {record_count_reg, fills};

    always_comb
    begin
        skip_threshold_next     = skip_threshold_reg;
        threshold_in_block_next = threshold_in_block_reg;
        in_block_next           = in_block_reg;
        record_position_next    = record_position_reg;
        record_count_next       = record_count_reg;
        if (accept)
        begin
            if (mode == MODE_START)
            begin
                skip_threshold_next  = time_index;
                record_position_next = '0;
                record_count_next    = '0;
                in_block_next        = 1'b0;
            end
            else
            begin
                threshold_in_block_next = threshold;
                in_block_next           = 1'b1;
                if (keep)
                begin
                    if (fills)
                    begin
                        record_position_next = '0;
                        record_count_next    = record_count_reg + RNUM_W'(1);
                    end
                    else
                    begin
                        record_position_next = pos_inc[POS_W-1:0];
                    end
                end
                if (block_end)
                begin
                    skip_threshold_next = time_index + TIME_W'(1);
                    in_block_next       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_threshold_reg     <= '0;
            threshold_in_block_reg <= '0;
            in_block_reg           <= 1'b0;
            record_position_reg    <= '0;
            record_count_reg       <= '0;
        end
        else
        begin
            skip_threshold_reg     <= skip_threshold_next;
            threshold_in_block_reg <= threshold_in_block_next;
            in_block_reg           <= in_block_next;
            record_position_reg    <= record_position_next;
            record_count_reg       <= record_count_next;
        end
    end

    // A start clears both record counters.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_START) |=> record_position_reg == '0 && record_count_reg == '0)
        else $error("record counters not cleared after start");

    // A block end always closes the block.
    a_block_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_SAMPLE) && block_end |=> !in_block_reg)
        else $error("block still open after block end");

    // The record count moves only on an accepted transaction.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(record_count_reg))
        else $error("record count changed without a transaction");

endmodule
`default_nettype wire

// ----- sv/sdrf_quantizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample quantizer pipeline
// Subtracts the voltage floor, scales by the gain and clamps to the bit
// depth in three registered stages with per-stage flow control.
// ----------------------------------------------------------------------------
module sdrf_quantizer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [23:0]                volt_min,
    input  wire logic [31:0]                code_gain,
    input  wire logic [4:0]                 sample_bits,
    input  wire logic                       item_valid,
    input  wire logic [23:0]                voltage,
    input  wire sdrf_pkg::frame_tag_t       item_tag,
    output logic                            item_ready,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [15:0]                     code,
    output logic [31:0]                     record_number,
    output logic                            record_last
);
    import sdrf_pkg::*;

    logic                      s1_valid_reg;
    logic signed [DIFF_W-1:0]  s1_diff_reg;
    frame_tag_t                s1_tag_reg;
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    frame_tag_t                s2_tag_reg;
    logic                      out_valid_reg;
    logic [CODE_W-1:0]         out_code_reg;
    frame_tag_t                out_tag_reg;

    logic                      out_take;
    logic                      s2_ready;
    logic                      s1_ready;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic [PROD_W-PROD_FRAC-1:0] whole;
    logic [CODE_W-1:0]         ceiling;
    logic [CODE_W-1:0]         code_next;

    assign out_take   = !out_valid_reg || !result_stall;
    assign s2_ready   = !s2_valid_reg || out_take;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_ready = s1_ready;

    assign diff_next = $signed({voltage[VOLT_W-1], voltage})
                     - $signed({volt_min[VOLT_W-1], volt_min});
    assign gain_s    = $signed({1'b0, code_gain});
    assign prod_next = s1_diff_reg * gain_s;

    assign whole   = s2_prod_reg[PROD_W-1:PROD_FRAC];
    assign ceiling = code_ceiling(sample_bits);

    always_comb
    begin
        if (s2_prod_reg[PROD_W-1])
            code_next = '0;
        else if (whole > {{(PROD_W-PROD_FRAC-CODE_W){1'b0}}, ceiling})
            code_next = ceiling;
        else
            code_next = whole[CODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= item_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_take)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_diff_reg <= diff_next;
            s1_tag_reg  <= item_tag;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg <= prod_next;
            s2_tag_reg  <= s1_tag_reg;
        end
        if (out_take && s2_valid_reg)
        begin
            out_code_reg <= code_next;
            out_tag_reg  <= s2_tag_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign code          = out_code_reg;
    assign record_number = out_tag_reg.record_number;
    assign record_last   = out_tag_reg.record_last;

    // A held first stage keeps its sample until the next stage frees up.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_diff_reg))
        else $error("first stage lost a held sample");

    // A held product stays put while the output register is occupied.
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_take |=> s2_valid_reg && $stable(s2_prod_reg))
        else $error("product stage lost a held sample");

    // A stalled result stays on the output unchanged.
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_code_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- sv/sample_digitizer_record_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample digitizer record framer
// Drops samples below the block's skip threshold, quantizes the rest and
// frames them into numbered records.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock on the sample channel while
// sample_stall is low, starts of run and samples alike. For a kept sample
// the voltage subtraction is captured into the first stage at the accepting
// edge, then the gain multiply into the second stage and then the clamp into
// the output register, which drives the result channel. The drop decision,
// the skip threshold and the record counters are all resolved in the cycle
// the transaction is accepted, so a start, a dropped sample or a block end
// never costs extra cycles. Each of the three stages has its own flow
// control, so a stalled result channel only back-pressures the sample channel
// once all three stages are full.
// Configuration registers may be written only while no sample is in flight.
// ----------------------------------------------------------------------------
module sample_digitizer_record_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Sample channel.
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire logic        mode,
    input  wire logic [47:0] time_index,
    input  wire logic [23:0] voltage,
    input  wire logic        block_end,
    // Result channel.
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      code,
    output logic [31:0]      record_number,
    output logic             record_last
);
    import sdrf_pkg::*;

    logic [VOLT_W-1:0] volt_min_reg;
    logic [GAIN_W-1:0] code_gain_reg;
    logic [BITS_W-1:0] sample_bits_reg;
    logic [RLEN_W-1:0] record_length_reg;

    logic        accept;
    logic        keep;
    logic        q_ready;
    frame_tag_t  tag;

    // Configuration registers; only the low bits of the write data are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_min_reg      <= VOLT_MIN_RST;
            code_gain_reg     <= CODE_GAIN_RST;
            sample_bits_reg   <= SAMPLE_BITS_RST;
            record_length_reg <= REC_LEN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_VOLT_MIN:    volt_min_reg      <= cfg_data[VOLT_W-1:0];
                CFG_CODE_GAIN:   code_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_SAMPLE_BITS: sample_bits_reg   <= cfg_data[BITS_W-1:0];
                CFG_REC_LENGTH:  record_length_reg <= cfg_data[RLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Every transaction is accepted once the quantizer's first stage has room,
    // whether or not the item turns out to produce a result.
    assign sample_stall = !q_ready;
    assign accept       = sample_valid && q_ready;

    sdrf_frame_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mode          (mode),
        .time_index    (time_index),
        .block_end     (block_end),
        .record_length (record_length_reg),
        .keep          (keep),
        .tag           (tag)
    );

    sdrf_quantizer u_quant (
        .clk           (clk),
        .rst_n         (rst_n),
        .volt_min      (volt_min_reg),
        .code_gain     (code_gain_reg),
        .sample_bits   (sample_bits_reg),
        .item_valid    (sample_valid && keep),
        .voltage       (voltage),
        .item_tag      (tag),
        .item_ready    (q_ready),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .code          (code),
        .record_number (record_number),
        .record_last   (record_last)
    );

endmodule
`default_nettype wire
